>>> hw/rtl/pia_pkg.sv
// shared types, operation codes and constants of the integer arithmetic unit
`default_nettype none
package pia_pkg;

    localparam int unsigned DataWidth = 64;
    localparam int unsigned OpWidth   = 5;
    localparam int unsigned ImmWidth  = 16;

    typedef enum logic [OpWidth-1:0] {
        OP_ADD    = 5'd0,
        OP_ADDE   = 5'd1,
        OP_ADDI   = 5'd2,
        OP_ADDIC  = 5'd3,
        OP_ADDIS  = 5'd4,
        OP_ADDZE  = 5'd5,
        OP_ADDME  = 5'd6,
        OP_ADDC   = 5'd7,
        OP_DIVD   = 5'd8,
        OP_DIVDU  = 5'd9,
        OP_DIVW   = 5'd10,
        OP_DIVWU  = 5'd11,
        OP_MULHW  = 5'd12,
        OP_MULHWU = 5'd13,
        OP_MULLD  = 5'd14,
        OP_MULLI  = 5'd15,
        OP_MULLW  = 5'd16,
        OP_MULHD  = 5'd17,
        OP_MULHDU = 5'd18,
        OP_NEG    = 5'd19,
        OP_SUBF   = 5'd20,
        OP_SUBFC  = 5'd21,
        OP_SUBFE  = 5'd22,
        OP_SUBFIC = 5'd23,
        OP_SUBFZE = 5'd24,
        OP_SUBFME = 5'd25
    } op_t;

    // kind of work an operation needs
    typedef enum logic [1:0] {
        KIND_ALU = 2'd0,
        KIND_MUL = 2'd1,
        KIND_DIV = 2'd2
    } kind_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture operands
        logic alu_done;   // latch adder result
        logic mul_step;   // accumulate one partial product
        logic mul_done;   // form multiply result
        logic div_step;   // one quotient bit
        logic div_done;   // form divide result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  last_step;
    } status_t;

    function automatic kind_t op_kind(input logic [OpWidth-1:0] op);
        kind_t k;
        k = KIND_ALU;
        case (op)
            OP_DIVD, OP_DIVDU, OP_DIVW, OP_DIVWU: k = KIND_DIV;
            OP_MULHW, OP_MULHWU, OP_MULLD, OP_MULLI,
            OP_MULLW, OP_MULHD, OP_MULHDU:         k = KIND_MUL;
            default:                               k = KIND_ALU;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/pia_ctrl.sv
// controller state machine of the integer arithmetic unit
`default_nettype none
module pia_ctrl
    import pia_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_fire,
    input  wire logic    out_busy,
    input  wire status_t status,
    output logic         ready_in,
    output logic         out_load,
    output cmd_t         cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DEC  = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        ready_in   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                ready_in = 1'b1;
                cmd.load = in_fire;
                if (in_fire)
                    state_next = S_DEC;
            end
            S_DEC:
            begin
                case (status.kind)
                    KIND_MUL: state_next = S_MUL;
                    KIND_DIV: state_next = S_DIV;
                    default:
                    begin
                        cmd.alu_done = 1'b1;
                        state_next   = S_FIN;
                    end
                endcase
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (status.last_step)
                begin
                    cmd.mul_done = 1'b1;
                    state_next   = S_FIN;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.last_step)
                begin
                    cmd.div_done = 1'b1;
                    state_next   = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_busy)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE)
        else $error("operand load outside idle");
    a_out_fin: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> state_reg == S_IDLE)
        else $error("output load did not return to idle");
    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.mul_step && cmd.div_step))
        else $error("multiply and divide step together");

endmodule
`default_nettype wire

>>> hw/rtl/pia_datapath.sv
// operand registers, adder, 32x32 multiply iteration and restoring divider
`default_nettype none
module pia_datapath
    import pia_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cmd_t                 cmd,
    input  wire logic [OpWidth-1:0]   req_type,
    input  wire logic [DataWidth-1:0] src_a,
    input  wire logic [DataWidth-1:0] src_b,
    input  wire logic [ImmWidth-1:0]  immediate,
    input  wire logic                 a_is_zero_reg,
    output status_t                   status,
    output logic [DataWidth-1:0]      res,
    output logic                      carry
);

    localparam int unsigned DW = DataWidth;
    localparam int unsigned HW = DW / 2;
    localparam int unsigned CW = $clog2(DW + 1);

    logic [OpWidth-1:0] op_reg;
    logic [DW-1:0]      a_reg, b_reg, imm_reg;
    logic               az_reg;
    logic               carry_reg, carry_next;
    logic [DW-1:0]      res_reg, res_next;

    // multiplier: four 32x32 partial products, one per step
    logic [DW-1:0]   ma_reg, mb_reg;
    logic [2*DW-1:0] acc_reg;
    logic [1:0]      pp_reg;
    logic            mneg_reg;
    logic [DW-1:0]   pp;
    logic [2*DW-1:0] pp_sh, acc_sum, prod;
    logic [HW-1:0]   pa, pb;

    // divider: one quotient bit per step
    logic [DW-1:0] q_reg, r_reg, d_reg;
    logic [CW-1:0] cnt_reg;
    logic          qneg_reg, dzero_reg;
    logic [DW:0]   trial;
    logic [DW-1:0] r_shift;

    logic [DW-1:0] a_s, b_s, imm_s, abs_a, abs_b;
    logic [HW-1:0] a32, b32, i32, na32;
    logic          ca;
    logic          is_word, sgn, na, nb, mul_signed;

    always_comb
    begin
        a32   = a_reg[HW-1:0];
        b32   = b_reg[HW-1:0];
        i32   = imm_reg[HW-1:0];
        na32  = ~a32;
        ca    = carry_reg;
        // word forms use the low halves, sign-extended when signed, zero-extended when unsigned
        is_word = (op_reg == OP_MULHW) || (op_reg == OP_MULLW) || (op_reg == OP_DIVW)
                  || (op_reg == OP_DIVWU) || (op_reg == OP_MULHWU);
        if (is_word && !(op_reg == OP_DIVWU || op_reg == OP_MULHWU))
        begin
            a_s = {{HW{a32[HW-1]}}, a32};
            b_s = {{HW{b32[HW-1]}}, b32};
        end
        else if (is_word)
        begin
            a_s = {{HW{1'b0}}, a32};
            b_s = {{HW{1'b0}}, b32};
        end
        else
        begin
            a_s = a_reg;
            b_s = (op_reg == OP_MULLI) ? imm_reg : b_reg;
        end
        sgn = (op_reg == OP_DIVD) || (op_reg == OP_DIVW) || (op_reg == OP_MULHW)
              || (op_reg == OP_MULLD) || (op_reg == OP_MULLI) || (op_reg == OP_MULLW)
              || (op_reg == OP_MULHD);
        mul_signed = sgn;
        na    = sgn && a_s[DW-1];
        nb    = sgn && b_s[DW-1];
        abs_a = na ? (~a_s + 1'b1) : a_s;
        abs_b = nb ? (~b_s + 1'b1) : b_s;
        imm_s = imm_reg;
    end

    // combinational adder group
    logic [HW:0] c33;
    always_comb
    begin
        res_next   = '0;
        carry_next = carry_reg;
        c33        = '0;
        case (op_reg)
            OP_ADD:  res_next = a_reg + b_reg;
            OP_ADDE:
            begin
                res_next = a_reg + b_reg + {{(DW-1){1'b0}}, ca};
                c33 = {1'b0, a32} + {1'b0, b32} + {{HW{1'b0}}, ca};
                carry_next = c33[HW];
            end
            OP_ADDI: res_next = (az_reg ? '0 : a_reg) + imm_s;
            OP_ADDIC:
            begin
                res_next = a_reg + imm_s;
                c33 = {1'b0, a32} + {1'b0, i32};
                carry_next = c33[HW];
            end
            OP_ADDIS: res_next = (az_reg ? '0 : a_reg)
                                 + {{(DW-2*ImmWidth){imm_reg[ImmWidth-1]}},
                                    imm_reg[ImmWidth-1:0], {ImmWidth{1'b0}}};
            OP_ADDZE:
            begin
                res_next = a_reg + {{(DW-1){1'b0}}, ca};
                c33 = {1'b0, a32} + {{HW{1'b0}}, ca};
                carry_next = c33[HW];
            end
            OP_ADDME:
            begin
                res_next = a_reg + {{(DW-1){1'b0}}, ca} + {DW{1'b1}};
                c33 = {1'b0, a32} + {1'b0, {HW{1'b1}}} + {{HW{1'b0}}, ca};
                carry_next = c33[HW];
            end
            OP_ADDC:
            begin
                res_next = a_reg + b_reg;
                c33 = {1'b0, a32} + {1'b0, b32};
                carry_next = c33[HW];
            end
            OP_NEG:  res_next = '0 - a_reg;
            OP_SUBF: res_next = b_reg - a_reg;
            OP_SUBFC:
            begin
                res_next = b_reg - a_reg;
                c33 = {1'b0, na32} + {1'b0, b32} + {{HW{1'b0}}, 1'b1};
                carry_next = c33[HW];
            end
            OP_SUBFE:
            begin
                res_next = ~a_reg + b_reg + {{(DW-1){1'b0}}, ca};
                c33 = {1'b0, na32} + {1'b0, b32} + {{HW{1'b0}}, ca};
                carry_next = c33[HW];
            end
            OP_SUBFIC:
            begin
                res_next = imm_s - a_reg;
                c33 = {1'b0, na32} + {1'b0, i32} + {{HW{1'b0}}, 1'b1};
                carry_next = c33[HW];
            end
            OP_SUBFZE:
            begin
                res_next = ~a_reg + {{(DW-1){1'b0}}, ca};
                c33 = {1'b0, na32} + {{HW{1'b0}}, ca};
                carry_next = c33[HW];
            end
            OP_SUBFME:
            begin
                res_next = ~a_reg + {{(DW-1){1'b0}}, ca} + {DW{1'b1}};
                c33 = {1'b0, na32} + {1'b0, {HW{1'b1}}} + {{HW{1'b0}}, ca};
                carry_next = c33[HW];
            end
            default: res_next = '0;
        endcase
    end

    // partial product select
    always_comb
    begin
        pa    = pp_reg[0] ? ma_reg[DW-1:HW] : ma_reg[HW-1:0];
        pb    = pp_reg[1] ? mb_reg[DW-1:HW] : mb_reg[HW-1:0];
        pp    = {{HW{1'b0}}, pa} * {{HW{1'b0}}, pb};
        case (pp_reg)
            2'd0:    pp_sh = {{DW{1'b0}}, pp};
            2'd3:    pp_sh = {pp, {DW{1'b0}}};
            default: pp_sh = {{HW{1'b0}}, pp, {HW{1'b0}}};
        endcase
        acc_sum = acc_reg + pp_sh;
        prod    = mneg_reg ? (~acc_sum + 1'b1) : acc_sum;
    end

    // restoring division step
    always_comb
    begin
        r_shift = {r_reg[DW-2:0], q_reg[DW-1]};
        trial   = {1'b0, r_shift} - {1'b0, d_reg};
    end

    always_comb
    begin
        status.kind = op_kind(op_reg);
        if (status.kind == KIND_MUL)
            status.last_step = (pp_reg == 2'd3);
        else
            status.last_step = (cnt_reg == CW'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            carry_reg <= 1'b0;
        else if (cmd.alu_done)
            carry_reg <= carry_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req_type;
            a_reg   <= src_a;
            b_reg   <= src_b;
            imm_reg <= {{(DW-ImmWidth){immediate[ImmWidth-1]}}, immediate};
            az_reg  <= a_is_zero_reg;
        end
        if (status.kind == KIND_MUL && !cmd.mul_step)
        begin
            ma_reg   <= abs_a;
            mb_reg   <= abs_b;
            acc_reg  <= '0;
            pp_reg   <= 2'd0;
            mneg_reg <= mul_signed && (na != nb);
        end
        else if (cmd.mul_step)
        begin
            acc_reg <= acc_sum;
            pp_reg  <= pp_reg + 2'd1;
        end
        if (status.kind == KIND_DIV && !cmd.div_step)
        begin
            q_reg     <= abs_a;
            r_reg     <= '0;
            d_reg     <= abs_b;
            cnt_reg   <= CW'(DW);
            qneg_reg  <= na != nb;
            // divide by zero, or most negative by minus one, at word or doubleword size
            dzero_reg <= (abs_b == '0) || (sgn && b_s == {DW{1'b1}}
                         && (is_word ? (a_s == {{(HW+1){1'b1}}, {(HW-1){1'b0}}})
                                     : (a_s == {1'b1, {(DW-1){1'b0}}})));
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (!trial[DW])
            begin
                r_reg <= trial[DW-1:0];
                q_reg <= {q_reg[DW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r_shift;
                q_reg <= {q_reg[DW-2:0], 1'b0};
            end
        end
        if (cmd.alu_done)
            res_reg <= res_next;
        else if (cmd.mul_done)
        begin
            case (op_reg)
                OP_MULHW:  res_reg <= {{HW{prod[DW-1]}}, prod[DW-1:HW]};
                OP_MULHWU: res_reg <= {{HW{1'b0}}, prod[DW-1:HW]};
                OP_MULHD, OP_MULHDU: res_reg <= prod[2*DW-1:DW];
                default:   res_reg <= prod[DW-1:0];
            endcase
        end
        else if (cmd.div_done)
        begin
            if (dzero_reg)
                res_reg <= '0;
            else if (is_word)
                res_reg <= {{HW{1'b0}}, (qneg_reg ? (~{q_reg[HW-2:0], !trial[DW]} + 1'b1)
                            : {q_reg[HW-2:0], !trial[DW]}) };
            else
                res_reg <= qneg_reg ? (~{q_reg[DW-2:0], !trial[DW]} + 1'b1)
                           : {q_reg[DW-2:0], !trial[DW]};
        end
    end

    assign res   = res_reg;
    assign carry = carry_reg;

endmodule
`default_nettype wire

>>> hw/rtl/ppc_integer_arith_unit_top.sv
// top level of the integer arithmetic unit: controller, datapath and output register
// path from acceptance to result valid: decode, then the multiply or divide steps if any,
// then the finish state, which waits while the receiver still holds the previous result
// throughput: one item at a time; the next can be taken in the same cycle that the result
// is in the output register
// reset: rst_n asynchronous active low clears the controller, carry flag and output valid
`default_nettype none
module ppc_integer_arith_unit_top
    import pia_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // req_type[4:0], src_a[68:5], src_b[132:69], immediate[148:133], a_is_zero_reg[149]
    input  wire logic [151:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // result[63:0], carry_out[64]
    output logic [71:0]      m_tdata
);

    localparam int unsigned DW = DataWidth;

    cmd_t          cmd;
    status_t       status;
    logic          in_fire, out_load, ready_in;
    logic [DW-1:0] res;
    logic          carry;
    logic          mvalid_reg;
    logic [DW:0]   mdata_reg;

    assign in_fire  = s_tvalid && ready_in;
    assign s_tready = ready_in;

    pia_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_busy (mvalid_reg && !m_tready),
        .status   (status),
        .ready_in (ready_in),
        .out_load (out_load),
        .cmd      (cmd)
    );

    pia_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .req_type      (s_tdata[4:0]),
        .src_a         (s_tdata[68:5]),
        .src_b         (s_tdata[132:69]),
        .immediate     (s_tdata[148:133]),
        .a_is_zero_reg (s_tdata[149]),
        .status        (status),
        .res           (res),
        .carry         (carry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mvalid_reg <= 1'b0;
        else if (out_load)
            mvalid_reg <= 1'b1;
        else if (m_tready)
            mvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            mdata_reg <= {carry, res};
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {{(72-DW-1){1'b0}}, mdata_reg};

endmodule
`default_nettype wire
